@@ design/jsu_pkg.sv @@
// Shared types, codes and helper functions for the JSON string unescape block.
package jsu_pkg;

  // Decoder modes
  localparam logic [2:0] MODE_IDLE   = 3'd0;
  localparam logic [2:0] MODE_BODY   = 3'd1;
  localparam logic [2:0] MODE_ESC    = 3'd2;
  localparam logic [2:0] MODE_HEX    = 3'd3;
  localparam logic [2:0] MODE_SUR_BS = 3'd4;
  localparam logic [2:0] MODE_SUR_U  = 3'd5;
  localparam logic [2:0] MODE_HEX2   = 3'd6;

  // Result kinds
  localparam logic [1:0] KIND_BYTE = 2'd0;
  localparam logic [1:0] KIND_DONE = 2'd1;
  localparam logic [1:0] KIND_FAIL = 2'd2;

  // Failure codes
  localparam logic [2:0] ERR_NONE   = 3'd0;
  localparam logic [2:0] ERR_LONG   = 3'd1;
  localparam logic [2:0] ERR_CTRL   = 3'd2;
  localparam logic [2:0] ERR_ESC    = 3'd3;
  localparam logic [2:0] ERR_UNTERM = 3'd4;

  localparam logic [15:0] MAX_LEN_RESET = 16'd4096;

  // Input request
  typedef struct packed {
    logic [7:0] data_byte;
    logic       text_end;
  } req_t;

  // Output result
  typedef struct packed {
    logic [7:0] out_byte;
    logic [1:0] kind;
    logic [2:0] error_code;
    logic       last;
  } rsp_t;

  // Decoder state
  typedef struct packed {
    logic [2:0]  mode;
    logic [1:0]  hex_cnt;
    logic [15:0] high_unit;
    logic [15:0] low_unit;
    logic [16:0] count;
  } state_t;

  // Results caused by one request: n is the number of results minus one
  typedef struct packed {
    logic            vld;
    logic [1:0]      n;
    logic [1:0]      kind;
    logic [2:0]      err;
    logic [3:0][7:0] bytes;
  } grp_t;

  // Hex digit value, 16 when the byte is not a hex digit
  function automatic logic [4:0] hex_value(input logic [7:0] c);
    logic [4:0] h;
    begin
      h = 5'd16;
      if (c >= 8'h30 && c <= 8'h39) h = 5'(c - 8'h30);
      else if (c >= 8'h61 && c <= 8'h66) h = 5'(c - 8'h61 + 8'd10);
      else if (c >= 8'h41 && c <= 8'h46) h = 5'(c - 8'h41 + 8'd10);
      return h;
    end
  endfunction

  // UTF-8 encode one code point into a result group
  function automatic grp_t encode_cp(input logic [20:0] cp);
    grp_t g;
    begin
      g      = '0;
      g.vld  = 1'b1;
      g.kind = KIND_BYTE;
      if (cp < 21'h80) begin
        g.n        = 2'd0;
        g.bytes[0] = cp[7:0];
      end else if (cp < 21'h800) begin
        g.n        = 2'd1;
        g.bytes[0] = 8'hc0 | {3'b0, cp[10:6]};
        g.bytes[1] = 8'h80 | {2'b0, cp[5:0]};
      end else if (cp < 21'h10000) begin
        g.n        = 2'd2;
        g.bytes[0] = 8'he0 | {4'b0, cp[15:12]};
        g.bytes[1] = 8'h80 | {2'b0, cp[11:6]};
        g.bytes[2] = 8'h80 | {2'b0, cp[5:0]};
      end else begin
        g.n        = 2'd3;
        g.bytes[0] = 8'hf0 | {5'b0, cp[20:18]};
        g.bytes[1] = 8'h80 | {2'b0, cp[17:12]};
        g.bytes[2] = 8'h80 | {2'b0, cp[11:6]};
        g.bytes[3] = 8'h80 | {2'b0, cp[5:0]};
      end
      return g;
    end
  endfunction

endpackage

@@ design/jsu_step.sv @@
// Next-state and result-group logic for one input byte of the string decoder.
module jsu_step (
  input  jsu_pkg::state_t st,
  input  jsu_pkg::req_t   req,
  input  logic [15:0]     max_len,
  output jsu_pkg::state_t st_next,
  output jsu_pkg::grp_t   grp
);

  logic [7:0]  c;
  logic [4:0]  h;
  logic [15:0] unit;
  logic [15:0] v;
  logic [20:0] cp;
  logic        esc_hit;
  logic [7:0]  esc_byte;

  assign c    = req.data_byte;
  assign h    = jsu_pkg::hex_value(c);
  assign unit = (st.mode == jsu_pkg::MODE_HEX2) ? st.low_unit : st.high_unit;
  assign v    = {unit[11:0], h[3:0]};
  // Join a surrogate pair: high unit is already stored, low unit is v
  assign cp   = 21'h10000 + {1'b0, st.high_unit[9:0], v[9:0]};

  // Map a simple escape letter to its byte
  always_comb begin
    esc_hit  = 1'b1;
    esc_byte = 8'h00;
    case (c)
      8'h22:   esc_byte = 8'h22;
      8'h5c:   esc_byte = 8'h5c;
      8'h2f:   esc_byte = 8'h2f;
      8'h62:   esc_byte = 8'h08;
      8'h66:   esc_byte = 8'h0c;
      8'h6e:   esc_byte = 8'h0a;
      8'h72:   esc_byte = 8'h0d;
      8'h74:   esc_byte = 8'h09;
      default: esc_hit = 1'b0;
    endcase
  end

  // Decode one request
  always_comb begin
    logic       fail;
    logic       done;
    logic [2:0] err;
    logic       emit;
    jsu_pkg::grp_t eg;

    st_next = st;
    grp     = '0;
    fail    = 1'b0;
    done    = 1'b0;
    err     = jsu_pkg::ERR_NONE;
    emit    = 1'b0;
    eg      = '0;

    if (st.mode == jsu_pkg::MODE_IDLE) begin
      // Take any byte as the opening quote
      if (!req.text_end) begin
        st_next.mode    = jsu_pkg::MODE_BODY;
        st_next.hex_cnt = 2'd0;
        st_next.count   = '0;
      end
    end else if (req.text_end) begin
      fail = 1'b1;
      err  = (st.mode == jsu_pkg::MODE_BODY || st.mode == jsu_pkg::MODE_ESC) ?
             jsu_pkg::ERR_UNTERM : jsu_pkg::ERR_ESC;
    end else begin
      unique case (st.mode)
        jsu_pkg::MODE_BODY: begin
          if (c == 8'h22) begin
            done = 1'b1;
          end else if (st.count >= {1'b0, max_len}) begin
            fail = 1'b1;
            err  = jsu_pkg::ERR_LONG;
          end else if (c < 8'h20) begin
            fail = 1'b1;
            err  = jsu_pkg::ERR_CTRL;
          end else if (c == 8'h5c) begin
            st_next.mode = jsu_pkg::MODE_ESC;
          end else begin
            // Pass a plain byte through as is
            emit        = 1'b1;
            eg.vld      = 1'b1;
            eg.kind     = jsu_pkg::KIND_BYTE;
            eg.bytes[0] = c;
          end
        end
        jsu_pkg::MODE_ESC: begin
          if (c == 8'h75) begin
            st_next.mode      = jsu_pkg::MODE_HEX;
            st_next.hex_cnt   = 2'd0;
            st_next.high_unit = '0;
          end else if (esc_hit) begin
            emit = 1'b1;
            eg   = jsu_pkg::encode_cp({13'b0, esc_byte});
          end else begin
            fail = 1'b1;
            err  = jsu_pkg::ERR_ESC;
          end
        end
        jsu_pkg::MODE_HEX, jsu_pkg::MODE_HEX2: begin
          if (h[4]) begin
            fail = 1'b1;
            err  = jsu_pkg::ERR_ESC;
          end else begin
            if (st.mode == jsu_pkg::MODE_HEX2) st_next.low_unit = v;
            else st_next.high_unit = v;
            st_next.hex_cnt = st.hex_cnt + 2'd1;
            if (st.hex_cnt == 2'd3) begin
              if (st.mode == jsu_pkg::MODE_HEX) begin
                if (v >= 16'hd800 && v < 16'hdc00) begin
                  st_next.mode = jsu_pkg::MODE_SUR_BS;
                end else if ((v >= 16'hdc00 && v < 16'he000) || v == 16'h0000) begin
                  fail = 1'b1;
                  err  = jsu_pkg::ERR_ESC;
                end else begin
                  emit = 1'b1;
                  eg   = jsu_pkg::encode_cp({5'b0, v});
                end
              end else if (v < 16'hdc00 || v >= 16'he000) begin
                fail = 1'b1;
                err  = jsu_pkg::ERR_ESC;
              end else begin
                emit = 1'b1;
                eg   = jsu_pkg::encode_cp(cp);
              end
            end
          end
        end
        jsu_pkg::MODE_SUR_BS: begin
          if (c == 8'h5c) begin
            st_next.mode = jsu_pkg::MODE_SUR_U;
          end else begin
            fail = 1'b1;
            err  = jsu_pkg::ERR_ESC;
          end
        end
        jsu_pkg::MODE_SUR_U: begin
          if (c == 8'h75) begin
            st_next.mode     = jsu_pkg::MODE_HEX2;
            st_next.hex_cnt  = 2'd0;
            st_next.low_unit = '0;
          end else begin
            fail = 1'b1;
            err  = jsu_pkg::ERR_ESC;
          end
        end
        default: st_next.mode = jsu_pkg::MODE_IDLE;
      endcase
    end

    // Drive the result group and finish the state update
    if (fail || done) begin
      st_next.mode    = jsu_pkg::MODE_IDLE;
      st_next.hex_cnt = 2'd0;
      st_next.count   = '0;
      grp.vld         = 1'b1;
      grp.n           = 2'd0;
      grp.kind        = fail ? jsu_pkg::KIND_FAIL : jsu_pkg::KIND_DONE;
      grp.err         = err;
    end else if (emit) begin
      st_next.mode  = jsu_pkg::MODE_BODY;
      st_next.count = st.count + 17'(eg.n) + 17'd1;
      grp           = eg;
    end
  end

endmodule

@@ design/json_string_unescape_utf8.sv @@
// Top level of the JSON string unescape block: state, length register and result serializer.
// Decodes a JSON string body one raw byte per request and returns UTF-8 bytes, a closing
// result or a failure, one result per cycle on the rsp channel while rsp_stall is low. A
// request is decoded in the cycle it is accepted; its results (one to four) appear from the
// next cycle on. Requests giving at most one result go at one per cycle while rsp_stall is
// low; more results stall req until the single result register has sent them. The user writes
// max_len via cfg_write/cfg_data only while no string is in flight; the block does not check.
module json_string_unescape_utf8 (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  output logic           req_stall,
  input  jsu_pkg::req_t  req,
  output logic           rsp_valid,
  input  logic           rsp_stall,
  output jsu_pkg::rsp_t  rsp,
  input  logic           cfg_write,
  input  logic [15:0]    cfg_data
);

  jsu_pkg::state_t st;
  jsu_pkg::state_t st_next;
  jsu_pkg::grp_t   step_grp;
  jsu_pkg::grp_t   grp;
  logic [15:0]     max_len;
  logic            busy;
  logic [1:0]      idx;
  logic            req_take;
  logic            rsp_take;
  logic            drain_last;

  jsu_step u_step (
    .st      (st),
    .req     (req),
    .max_len (max_len),
    .st_next (st_next),
    .grp     (step_grp)
  );

  assign rsp_take   = rsp_valid && !rsp_stall;
  assign drain_last = rsp_take && (idx == grp.n);
  assign req_stall  = busy && !drain_last;
  assign req_take   = req_valid && !req_stall;

  // Present the current result of the held group
  assign rsp_valid      = busy;
  assign rsp.out_byte   = grp.bytes[idx];
  assign rsp.kind       = grp.kind;
  assign rsp.error_code = grp.err;
  assign rsp.last       = (idx == grp.n);

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      st      <= '0;
      max_len <= jsu_pkg::MAX_LEN_RESET;
      busy    <= 1'b0;
      idx     <= 2'd0;
    end else begin
      if (cfg_write) max_len <= cfg_data;
      if (req_take) st <= st_next;
      if (req_take && step_grp.vld) begin
        // Load a new group
        busy <= 1'b1;
        idx  <= 2'd0;
      end else if (rsp_take) begin
        // Advance through the group, drop it after the last result
        if (drain_last) begin
          busy <= 1'b0;
          idx  <= 2'd0;
        end else begin
          idx <= idx + 2'd1;
        end
      end
    end
  end

  // Hold the result group payload
  always_ff @(posedge clk) begin
    if (req_take && step_grp.vld) grp <= step_grp;
  end

endmodule

@@ design/jsu_checker.sv @@
// Port-level assertions for the JSON string unescape block, bound to its top level.
module jsu_checker (
  input logic          clk,
  input logic          rst,
  input logic          rsp_valid,
  input logic          rsp_stall,
  input jsu_pkg::rsp_t rsp
);

  // Hold a stalled result
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
    else $error("stalled result changed");

  // Close every string or failure with a single last result
  a_end_alone: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.kind != jsu_pkg::KIND_BYTE |-> rsp.last && rsp.out_byte == 8'h00)
    else $error("closing or failure result not alone");

  // Carry a failure code on failures only
  a_fail_code: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.kind == jsu_pkg::KIND_FAIL |->
      rsp.error_code == jsu_pkg::ERR_LONG || rsp.error_code == jsu_pkg::ERR_CTRL ||
      rsp.error_code == jsu_pkg::ERR_ESC || rsp.error_code == jsu_pkg::ERR_UNTERM)
    else $error("failure without a valid code");

  a_byte_code: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.kind != jsu_pkg::KIND_FAIL |-> rsp.error_code == jsu_pkg::ERR_NONE)
    else $error("error code on a non-failure result");

  // Drop results on reset
  a_reset_empty: assert property (@(posedge clk) rst |=> !rsp_valid)
    else $error("result pending after reset");

endmodule

bind json_string_unescape_utf8 jsu_checker u_jsu_checker (.*);

@@ test/tb.sv @@
// Testbench for the JSON string unescape block: random strings and failures, scoreboard checked.
`timescale 1ns / 100ps

module tb;

  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5c;
  localparam logic [7:0] CH_U      = 8'h75;

  // Predicts decoded output per raw request and checks the block's results against it
  class unescape_sb;
    logic [15:0]   max_len;
    logic [2:0]    mode;
    logic [1:0]    hex_cnt;
    logic [15:0]   high_unit;
    logic [15:0]   low_unit;
    logic [16:0]   count;
    jsu_pkg::rsp_t pending_out[$];
    jsu_pkg::rsp_t step_out[$];
    int            mismatches;

    function new();
      max_len    = jsu_pkg::MAX_LEN_RESET;
      mode       = jsu_pkg::MODE_IDLE;
      hex_cnt    = 2'd0;
      high_unit  = 16'd0;
      low_unit   = 16'd0;
      count      = 17'd0;
      mismatches = 0;
    endfunction

    // Emit one decoded byte and bump the length count
    function void push_byte(logic [7:0] b);
      jsu_pkg::rsp_t r;
      count = count + 17'd1;
      r = '{out_byte: b, kind: jsu_pkg::KIND_BYTE, error_code: jsu_pkg::ERR_NONE, last: 1'b0};
      step_out.push_back(r);
    endfunction

    // End the string with a done or failure result and go back to idle
    function void close_string(logic [1:0] k, logic [2:0] code);
      jsu_pkg::rsp_t r;
      mode    = jsu_pkg::MODE_IDLE;
      hex_cnt = 2'd0;
      count   = 17'd0;
      r = '{out_byte: 8'h00, kind: k, error_code: code, last: 1'b0};
      step_out.push_back(r);
    endfunction

    // Encode a code point as 1 to 4 UTF-8 bytes
    function void put_code_point(int unsigned cp);
      if (cp < 'h80) begin
        push_byte(8'(cp));
      end else if (cp < 'h800) begin
        push_byte(8'('hc0 | (cp >> 6)));
        push_byte(8'('h80 | (cp & 'h3f)));
      end else if (cp < 'h10000) begin
        push_byte(8'('he0 | (cp >> 12)));
        push_byte(8'('h80 | ((cp >> 6) & 'h3f)));
        push_byte(8'('h80 | (cp & 'h3f)));
      end else begin
        push_byte(8'('hf0 | (cp >> 18)));
        push_byte(8'('h80 | ((cp >> 12) & 'h3f)));
        push_byte(8'('h80 | ((cp >> 6) & 'h3f)));
        push_byte(8'('h80 | (cp & 'h3f)));
      end
      mode = jsu_pkg::MODE_BODY;
    endfunction

    // Bit 4 set means not a hex digit
    function logic [4:0] nibble_of(logic [7:0] c);
      if (c inside {[8'h30:8'h39]}) return {1'b0, 4'(c - 8'h30)};
      if (c inside {[8'h61:8'h66]}) return {1'b0, 4'(c - 8'h57)};
      if (c inside {[8'h41:8'h46]}) return {1'b0, 4'(c - 8'h37)};
      return 5'h10;
    endfunction

    // Shift one hex digit into a code unit; act on the fourth
    function void hex_digit(logic [7:0] c, bit second);
      logic [4:0]  h;
      logic [15:0] v;
      bit          done;
      h = nibble_of(c);
      if (h[4]) begin
        close_string(jsu_pkg::KIND_FAIL, jsu_pkg::ERR_ESC);
        return;
      end
      v = second ? {low_unit[11:0], h[3:0]} : {high_unit[11:0], h[3:0]};
      if (second) low_unit = v;
      else high_unit = v;
      done    = (hex_cnt == 2'd3);
      hex_cnt = hex_cnt + 2'd1;
      if (!done) return;
      if (!second) begin
        if (v >= 16'hd800 && v < 16'hdc00) mode = jsu_pkg::MODE_SUR_BS;
        else if ((v >= 16'hdc00 && v < 16'he000) || v == 16'h0000)
          close_string(jsu_pkg::KIND_FAIL, jsu_pkg::ERR_ESC);
        else put_code_point(32'(v));
      end else if (v < 16'hdc00 || v >= 16'he000) begin
        close_string(jsu_pkg::KIND_FAIL, jsu_pkg::ERR_ESC);
      end else begin
        put_code_point(32'h10000 + ((32'(high_unit) - 32'hd800) << 10)
                       + (32'(v) - 32'hdc00));
      end
    endfunction

    // Decode one accepted raw request and queue the results it causes
    function void decode_raw(jsu_pkg::req_t r);
      logic [7:0] c;
      c = r.data_byte;
      step_out.delete();
      if (mode == jsu_pkg::MODE_IDLE) begin
        if (!r.text_end) begin
          mode    = jsu_pkg::MODE_BODY;
          hex_cnt = 2'd0;
          count   = 17'd0;
        end
        return;
      end
      if (r.text_end) begin
        close_string(jsu_pkg::KIND_FAIL,
                     (mode == jsu_pkg::MODE_BODY || mode == jsu_pkg::MODE_ESC) ?
                     jsu_pkg::ERR_UNTERM : jsu_pkg::ERR_ESC);
      end else begin
        case (mode)
          jsu_pkg::MODE_BODY: begin
            if (c == CH_QUOTE) close_string(jsu_pkg::KIND_DONE, jsu_pkg::ERR_NONE);
            else if (count >= {1'b0, max_len})
              close_string(jsu_pkg::KIND_FAIL, jsu_pkg::ERR_LONG);
            else if (c < 8'h20) close_string(jsu_pkg::KIND_FAIL, jsu_pkg::ERR_CTRL);
            else if (c == CH_BSLASH) mode = jsu_pkg::MODE_ESC;
            else push_byte(c);
          end
          jsu_pkg::MODE_ESC: begin
            case (c)
              CH_QUOTE, CH_BSLASH, 8'h2f: begin
                mode = jsu_pkg::MODE_BODY;
                push_byte(c);
              end
              8'h62: begin mode = jsu_pkg::MODE_BODY; push_byte(8'h08); end
              8'h66: begin mode = jsu_pkg::MODE_BODY; push_byte(8'h0c); end
              8'h6e: begin mode = jsu_pkg::MODE_BODY; push_byte(8'h0a); end
              8'h72: begin mode = jsu_pkg::MODE_BODY; push_byte(8'h0d); end
              8'h74: begin mode = jsu_pkg::MODE_BODY; push_byte(8'h09); end
              CH_U: begin
                mode      = jsu_pkg::MODE_HEX;
                hex_cnt   = 2'd0;
                high_unit = 16'd0;
              end
              default: close_string(jsu_pkg::KIND_FAIL, jsu_pkg::ERR_ESC);
            endcase
          end
          jsu_pkg::MODE_HEX: hex_digit(c, 1'b0);
          jsu_pkg::MODE_SUR_BS: begin
            if (c == CH_BSLASH) mode = jsu_pkg::MODE_SUR_U;
            else close_string(jsu_pkg::KIND_FAIL, jsu_pkg::ERR_ESC);
          end
          jsu_pkg::MODE_SUR_U: begin
            if (c == CH_U) begin
              mode     = jsu_pkg::MODE_HEX2;
              hex_cnt  = 2'd0;
              low_unit = 16'd0;
            end else begin
              close_string(jsu_pkg::KIND_FAIL, jsu_pkg::ERR_ESC);
            end
          end
          jsu_pkg::MODE_HEX2: hex_digit(c, 1'b1);
          default: mode = jsu_pkg::MODE_IDLE;
        endcase
      end
      if (step_out.size() > 0) step_out[step_out.size() - 1].last = 1'b1;
      foreach (step_out[i]) pending_out.push_back(step_out[i]);
    endfunction

    // Compare one result with the oldest expected one
    function void check_out(jsu_pkg::rsp_t a);
      jsu_pkg::rsp_t e;
      if (pending_out.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: byte=%h kind=%0d err=%0d last=%b",
                   a.out_byte, a.kind, a.error_code, a.last);
        return;
      end
      e = pending_out.pop_front();
      if (a.out_byte !== e.out_byte || a.kind !== e.kind ||
          a.error_code !== e.error_code || a.last !== e.last) begin
        mismatches++;
        if (mismatches <= 10)
          $display({"mismatch: expected byte=%h kind=%0d err=%0d last=%b,",
                    " got byte=%h kind=%0d err=%0d last=%b"},
                   e.out_byte, e.kind, e.error_code, e.last,
                   a.out_byte, a.kind, a.error_code, a.last);
      end
    endfunction
  endclass

  logic          clk       = 1'b0;
  logic          rst       = 1'b1;
  logic          req_valid = 1'b0;
  logic          req_stall;
  jsu_pkg::req_t req       = '0;
  logic          rsp_valid;
  logic          rsp_stall = 1'b0;
  jsu_pkg::rsp_t rsp;
  logic          cfg_write = 1'b0;
  logic [15:0]   cfg_data  = 16'd0;

  unescape_sb  sb;
  int          burst_left = 0;
  int          gap_max    = 0;
  int          sent       = 0;
  int          noise_turn = 0;
  logic [9:0]  stall_tick = '0;
  logic [7:0]  esc_letters [8] = '{8'h22, 8'h5c, 8'h2f, 8'h62, 8'h66, 8'h6e, 8'h72, 8'h74};

  json_string_unescape_utf8 DUT (
    .clk(clk),
    .rst(rst),
    .req_valid(req_valid),
    .req_stall(req_stall),
    .req(req),
    .rsp_valid(rsp_valid),
    .rsp_stall(rsp_stall),
    .rsp(rsp),
    .cfg_write(cfg_write),
    .cfg_data(cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Stall the result side: free, light random, heavy random, then periodic
  always @(posedge clk) begin
    stall_tick <= stall_tick + 10'd1;
    case (stall_tick[9:8])
      2'd0: rsp_stall <= 1'b0;
      2'd1: rsp_stall <= ($urandom_range(0, 2) == 0);
      2'd2: rsp_stall <= ($urandom_range(0, 3) != 0);
      default: rsp_stall <= (stall_tick[3:0] < 4'd5);
    endcase
  end

  // Predict on accepted requests, check accepted results
  always @(posedge clk) begin
    if (!rst) begin
      if (req_valid && !req_stall) sb.decode_raw(req);
      if (rsp_valid && !rsp_stall) sb.check_out(rsp);
    end
  end

  function automatic logic [7:0] hex_char(input logic [3:0] n);
    if (n < 4'd10) return 8'h30 + 8'(n);
    return (($urandom_range(0, 1) != 0) ? 8'h61 : 8'h41) + 8'(n) - 8'd10;
  endfunction

  // Send one request; hold it until accepted, with random gaps between bursts
  task automatic put_byte(input logic [7:0] d, input logic e);
    int gap;
    begin
      if (burst_left == 0) begin
        gap = (gap_max == 0) ? 0 : $urandom_range(0, gap_max);
        if (gap > 0) begin
          req_valid <= 1'b0;
          repeat (gap) @(posedge clk);
        end
        burst_left = $urandom_range(1, 12);
      end
      req       <= '{data_byte: d, text_end: e};
      req_valid <= 1'b1;
      @(posedge clk);
      while (req_stall) @(posedge clk);
      burst_left--;
      sent++;
    end
  endtask

  task automatic put_char(input logic [7:0] c);
    put_byte(c, 1'b0);
  endtask

  task automatic put_end();
    put_byte(8'($urandom), 1'b1);
  endtask

  task automatic put_u(input logic [15:0] v);
    int i;
    begin
      put_char(CH_BSLASH);
      put_char(CH_U);
      for (i = 3; i >= 0; i--) put_char(hex_char(v[4*i +: 4]));
    end
  endtask

  // Drop valid, wait for all results, and close any string left open
  task automatic settle();
    begin
      req_valid <= 1'b0;
      burst_left = 0;
      @(posedge clk);
      while (sb.pending_out.size() != 0) @(posedge clk);
      repeat (4) @(posedge clk);
      while (sb.mode != jsu_pkg::MODE_IDLE) begin
        put_end();
        req_valid <= 1'b0;
        @(posedge clk);
        while (sb.pending_out.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
      end
    end
  endtask

  task automatic set_limit(input logic [15:0] v);
    begin
      cfg_write <= 1'b1;
      cfg_data  <= v;
      @(posedge clk);
      cfg_write <= 1'b0;
      sb.max_len = v;
    end
  endtask

  // Broken input, one variety per call in turn; each ends the string in failure
  task automatic put_noise();
    logic [7:0] c;
    int         k;
    int         i;
    begin
      case (noise_turn % 10)
        0: put_char(8'($urandom_range(0, 31)));
        1: begin
          do c = 8'($urandom);
          while (c inside {8'h22, 8'h5c, 8'h2f, 8'h62, 8'h66, 8'h6e, 8'h72, 8'h74, 8'h75});
          put_char(CH_BSLASH);
          put_char(c);
        end
        2: begin
          put_char(CH_BSLASH);
          put_char(CH_U);
          k = $urandom_range(0, 3);
          for (i = 0; i < k; i++) put_char(hex_char(4'($urandom)));
          do c = 8'($urandom);
          while (c inside {[8'h30:8'h39], [8'h41:8'h46], [8'h61:8'h66]});
          put_char(c);
        end
        3: put_u(16'($urandom_range('hdc00, 'hdfff)));
        4: begin
          put_u(16'($urandom_range('hd800, 'hdbff)));
          do c = 8'($urandom);
          while (c == CH_BSLASH);
          put_char(c);
        end
        5: begin
          put_u(16'($urandom_range('hd800, 'hdbff)));
          put_char(CH_BSLASH);
          do c = 8'($urandom);
          while (c == CH_U);
          put_char(c);
        end
        6: begin
          put_u(16'($urandom_range('hd800, 'hdbff)));
          put_u(($urandom_range(0, 1) != 0) ? 16'($urandom_range(0, 'hdbff))
                                            : 16'($urandom_range('he000, 'hffff)));
        end
        7: put_u(16'h0000);
        8: begin
          // text end inside a hex escape or a surrogate pair
          case ($urandom_range(0, 3))
            0: begin
              put_char(CH_BSLASH);
              put_char(CH_U);
              k = $urandom_range(0, 3);
              for (i = 0; i < k; i++) put_char(hex_char(4'($urandom)));
            end
            1: put_u(16'($urandom_range('hd800, 'hdbff)));
            2: begin
              put_u(16'($urandom_range('hd800, 'hdbff)));
              put_char(CH_BSLASH);
            end
            default: begin
              put_u(16'($urandom_range('hd800, 'hdbff)));
              put_char(CH_BSLASH);
              put_char(CH_U);
              k = $urandom_range(0, 3);
              for (i = 0; i < k; i++) put_char(hex_char(4'($urandom)));
            end
          endcase
          put_end();
        end
        default: begin
          put_char(CH_BSLASH);
          put_end();
        end
      endcase
      noise_turn++;
    end
  endtask

  // One string: opening byte, mixed body, then closing quote, text end or broken input
  task automatic rand_string();
    int         n;
    int         i;
    int         pick;
    logic [7:0] c;
    begin
      put_char(($urandom_range(0, 9) == 0) ? 8'($urandom) : CH_QUOTE);
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 48) : $urandom_range(0, 12);
      for (i = 0; i < n; i++) begin
        pick = $urandom_range(0, 99);
        if (pick < 50) begin
          do c = 8'($urandom_range('h20, 'hff));
          while (c == CH_QUOTE || c == CH_BSLASH);
          put_char(c);
        end else if (pick < 63) begin
          put_char(CH_BSLASH);
          put_char(esc_letters[3'($urandom_range(0, 7))]);
        end else if (pick < 76) begin
          case ($urandom_range(0, 3))
            0: put_u(16'($urandom_range(1, 'h7f)));
            1: put_u(16'($urandom_range('h80, 'h7ff)));
            2: put_u(16'($urandom_range('h800, 'hd7ff)));
            default: put_u(16'($urandom_range('he000, 'hffff)));
          endcase
        end else if (pick < 86) begin
          put_u(16'($urandom_range('hd800, 'hdbff)));
          put_u(16'($urandom_range('hdc00, 'hdfff)));
        end else begin
          put_noise();
          return;
        end
      end
      if ($urandom_range(0, 19) == 0) put_end();
      else put_char(CH_QUOTE);
    end
  endtask

  initial begin
    logic [15:0] limits [0:6];
    int          p;
    int          start;
    sb = new();
    limits[0] = 16'hffff;
    limits[1] = 16'd1;
    limits[2] = jsu_pkg::MAX_LEN_RESET;
    limits[3] = 16'd3;
    limits[4] = 16'd8;
    limits[5] = 16'($urandom_range(2, 40));
    limits[6] = 16'($urandom_range(1, 65535));
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Directed: idle text end, odd opener, byte extremes, unterminated cases
    put_end();
    put_char(8'hff);
    put_char(8'hff);
    put_char(8'h00);
    put_char(CH_QUOTE);
    put_char(CH_BSLASH);
    put_end();
    put_char(CH_QUOTE);
    put_end();
    // smallest surrogate pair, then an unknown escape letter
    put_char(CH_QUOTE);
    put_u(16'hd800);
    put_u(16'hdc00);
    put_char(CH_BSLASH);
    put_char(8'h78);
    settle();
    // zero limit refuses the first plain byte
    set_limit(16'd0);
    put_char(CH_QUOTE);
    put_char(8'h61);
    settle();

    // Random phases, one length limit each; gaps on odd phases only
    for (p = 0; p < 7; p++) begin
      set_limit(limits[p]);
      gap_max = (p % 2 != 0) ? 6 : 0;
      start = sent;
      while (sent - start < 56) begin
        if ($urandom_range(0, 14) == 0) put_end();
        rand_string();
      end
      settle();
    end

    repeat (8) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending_out.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // Bound the run
  initial begin
    #4_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
